/* design/csvfp_pkg.sv */
// ----------------------------------------------------------------------------
// csvfp_pkg: shared types and constants of the CSV field parser
// Holds the input classes, the queue entry, the parse phase and the event kinds.
// ----------------------------------------------------------------------------
package csvfp_pkg;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [1:0] MODE_DATA  = 2'd0;
	localparam logic [1:0] MODE_CHUNK = 2'd1;
	localparam logic [1:0] MODE_FINAL = 2'd2;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_COLEND = 2'd1;
	localparam logic [1:0] KIND_RECEND = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	typedef enum logic [2:0] {
		CLS_QUOTE,
		CLS_COMMA,
		CLS_EOL,
		CLS_OTHER,
		CLS_CHUNK,
		CLS_FINAL
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [7:0] data;
	} entry_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_DATA,
		PH_QSEEN,
		PH_AFTERQ
	} phase_t;

endpackage

/* design/csvfp_front.sv */
// ----------------------------------------------------------------------------
// csvfp_front: input classifier
// Sorts each accepted item into a character or marker class for the queue.
// ----------------------------------------------------------------------------
module csvfp_front (
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [1:0]        mode,
	input  logic [7:0]        data_byte,
	output logic              push_valid,
	input  logic              push_ready,
	output csvfp_pkg::entry_t push_entry
);

	always_comb begin
		push_entry.data = data_byte;
		push_entry.cls  = csvfp_pkg::CLS_OTHER;
		push_valid      = item_valid;
		case (mode)
			csvfp_pkg::MODE_DATA: begin
				if (data_byte == csvfp_pkg::CH_QUOTE) begin
					push_entry.cls = csvfp_pkg::CLS_QUOTE;
				end else if (data_byte == csvfp_pkg::CH_COMMA) begin
					push_entry.cls = csvfp_pkg::CLS_COMMA;
				end else if (data_byte inside {csvfp_pkg::CH_CR, csvfp_pkg::CH_LF}) begin
					push_entry.cls = csvfp_pkg::CLS_EOL;
				end
			end
			csvfp_pkg::MODE_CHUNK: push_entry.cls = csvfp_pkg::CLS_CHUNK;
			csvfp_pkg::MODE_FINAL: push_entry.cls = csvfp_pkg::CLS_FINAL;
			// The unused mode has no effect, so it is consumed here and never queued.
			default: push_valid = 1'b0;
		endcase
	end

	// An unused-mode transaction is dropped, so it never waits on the queue.
	assign item_ready = push_ready ||
		!(mode inside {csvfp_pkg::MODE_DATA, csvfp_pkg::MODE_CHUNK, csvfp_pkg::MODE_FINAL});

endmodule

/* design/csvfp_queue.sv */
// ----------------------------------------------------------------------------
// csvfp_queue: short entry queue
// A small register queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module csvfp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  csvfp_pkg::entry_t push_entry,
	output logic              pop_valid,
	input  logic              pop_ready,
	output csvfp_pkg::entry_t pop_entry
);

	csvfp_pkg::entry_t                    mem_q [csvfp_pkg::QUEUE_DEPTH];
	logic [csvfp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [csvfp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [csvfp_pkg::QUEUE_CNT_W-1:0]    count_q;
	logic                                 do_push;
	logic                                 do_pop;

	assign push_ready = (count_q != csvfp_pkg::QUEUE_CNT_W'(csvfp_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/csvfp_back.sv */
// ----------------------------------------------------------------------------
// csvfp_back: parse state machine and event register
// Runs one queued entry per cycle through the parser unless an event waits.
// ----------------------------------------------------------------------------
module csvfp_back #(
	parameter logic [7:0] COL_TOP = 8'd255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  csvfp_pkg::entry_t pop_entry,
	output logic              event_valid,
	input  logic              event_ready,
	output logic [1:0]        kind,
	output logic [7:0]        field_byte,
	output logic [7:0]        column_index
);

	csvfp_pkg::phase_t phase_q, phase_d;
	logic              quoted_q, quoted_d;
	logic [7:0]        col_q, col_d;
	logic              skip_q, skip_d;

	logic              ev_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        byte_q;
	logic [7:0]        colidx_q;

	logic              emit;
	logic [1:0]        emit_kind;
	logic [7:0]        emit_byte;
	logic              step;
	logic              in_quote;

	assign pop_ready = !ev_valid_q || event_ready;
	assign step      = pop_valid && pop_ready;
	assign in_quote  = (phase_q == csvfp_pkg::PH_DATA) && quoted_q;

	always_comb begin
		phase_d   = phase_q;
		quoted_d  = quoted_q;
		col_d     = col_q;
		skip_d    = skip_q;
		emit      = 1'b0;
		emit_kind = csvfp_pkg::KIND_BYTE;
		emit_byte = 8'd0;
		case (pop_entry.cls)
			csvfp_pkg::CLS_CHUNK: begin
				if (skip_q) begin
					skip_d = 1'b0;
				end else if (!in_quote) begin
					emit      = 1'b1;
					emit_kind = csvfp_pkg::KIND_RECEND;
				end
			end
			csvfp_pkg::CLS_FINAL: begin
				if (skip_q) begin
					phase_d  = csvfp_pkg::PH_START;
					quoted_d = 1'b0;
					col_d    = 8'd0;
					skip_d   = 1'b0;
				end else if (in_quote) begin
					emit      = 1'b1;
					emit_kind = csvfp_pkg::KIND_ERROR;
				end else if (!(phase_q == csvfp_pkg::PH_START && col_q == 8'd0)) begin
					emit      = 1'b1;
					emit_kind = csvfp_pkg::KIND_RECEND;
				end
			end
			default: begin
				if (!skip_q) begin
					case (phase_q)
						csvfp_pkg::PH_START: begin
							phase_d = csvfp_pkg::PH_DATA;
							if (pop_entry.cls == csvfp_pkg::CLS_QUOTE) begin
								quoted_d = 1'b1;
							end else begin
								quoted_d = 1'b0;
								emit     = 1'b1;
							end
						end
						csvfp_pkg::PH_DATA: begin
							if (quoted_q && pop_entry.cls == csvfp_pkg::CLS_QUOTE) begin
								phase_d = csvfp_pkg::PH_QSEEN;
							end else begin
								emit = 1'b1;
							end
						end
						csvfp_pkg::PH_QSEEN: begin
							if (pop_entry.cls == csvfp_pkg::CLS_QUOTE) begin
								// A doubled quote stands for one quote character.
								phase_d = csvfp_pkg::PH_DATA;
								emit    = 1'b1;
							end else begin
								phase_d = csvfp_pkg::PH_AFTERQ;
								emit    = 1'b1;
							end
						end
						default: emit = 1'b1;
					endcase
					// Decide what the emitted event is. Quoted data and a doubled
					// quote give a content byte; otherwise the class and phase decide.
					if (emit) begin
						if ((phase_q == csvfp_pkg::PH_DATA && quoted_q) ||
							(phase_q == csvfp_pkg::PH_QSEEN &&
							pop_entry.cls == csvfp_pkg::CLS_QUOTE)) begin
							emit_kind = csvfp_pkg::KIND_BYTE;
						end else if (pop_entry.cls == csvfp_pkg::CLS_COMMA) begin
							emit_kind = csvfp_pkg::KIND_COLEND;
						end else if (pop_entry.cls == csvfp_pkg::CLS_EOL) begin
							emit_kind = csvfp_pkg::KIND_RECEND;
							skip_d    = 1'b1;
						end else if (phase_q == csvfp_pkg::PH_QSEEN ||
							phase_q == csvfp_pkg::PH_AFTERQ) begin
							emit_kind = csvfp_pkg::KIND_ERROR;
						end else begin
							emit_kind = csvfp_pkg::KIND_BYTE;
						end
					end
				end
			end
		endcase

		if (emit) begin
			case (emit_kind)
				csvfp_pkg::KIND_BYTE: emit_byte = pop_entry.data;
				csvfp_pkg::KIND_COLEND: begin
					if (col_q < COL_TOP) begin
						col_d = col_q + 8'd1;
					end
					phase_d  = csvfp_pkg::PH_START;
					quoted_d = 1'b0;
				end
				csvfp_pkg::KIND_ERROR: begin
					phase_d  = csvfp_pkg::PH_START;
					quoted_d = 1'b0;
					col_d    = 8'd0;
					skip_d   = 1'b1;
				end
				default: begin
					phase_d  = csvfp_pkg::PH_START;
					quoted_d = 1'b0;
					col_d    = 8'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= csvfp_pkg::PH_START;
			quoted_q <= 1'b0;
			col_q    <= 8'd0;
			skip_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			quoted_q <= quoted_d;
			col_q    <= col_d;
			skip_q   <= skip_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (pop_ready) begin
			ev_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			kind_q   <= emit_kind;
			byte_q   <= emit_byte;
			colidx_q <= col_q;
		end
	end

	assign event_valid  = ev_valid_q;
	assign kind         = kind_q;
	assign field_byte   = byte_q;
	assign column_index = colidx_q;

endmodule

/* design/csv_field_parser.sv */
// An event is registered in the queue and then in the event register after its input
// transaction is accepted.
// Throughput: one input transaction per cycle while the queue has room; the parser
// retires one queued entry per cycle, limited only by the event register being taken.
// A four-entry queue between classifier and parser absorbs output stalls.
// Reset (arst_n low, asynchronous) empties the queue, clears the event register and
// returns the parser to the start of a record at column 0 with skipping off.
// ----------------------------------------------------------------------------
// csv_field_parser: streaming CSV field parser
// Turns a byte stream with chunk-end and final markers into field content bytes,
// column-end, record-end and parse-error events, each tagged with its column.
// ----------------------------------------------------------------------------
module csv_field_parser #(
	parameter int MAX_COLUMNS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] mode,
	input  logic [7:0] data_byte,
	output logic       event_valid,
	input  logic       event_ready,
	output logic [1:0] kind,
	output logic [7:0] field_byte,
	output logic [7:0] column_index
);

	// The column index saturates at the last column, capped by the 8-bit index field.
	localparam int         ColTopInt = ((MAX_COLUMNS - 1) > 255) ? 255 : (MAX_COLUMNS - 1);
	localparam logic [7:0] ColTop    = 8'(ColTopInt);

	logic              push_valid;
	logic              push_ready;
	csvfp_pkg::entry_t push_entry;
	logic              pop_valid;
	logic              pop_ready;
	csvfp_pkg::entry_t pop_entry;

	// The front end classifies each transaction: quote, comma, line end, other
	// byte, chunk end or final. The unused mode is absorbed at the input.
	csvfp_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.mode       (mode),
		.data_byte  (data_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// The queue lets the input keep flowing while the event register waits.
	csvfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// The back end holds the parse state (phase, quoted flag, column, skip flag)
	// and produces at most one event per entry into its output register. After an
	// error or unquoted line end it drops bytes until the next chunk-end or final marker.
	csvfp_back #(
		.COL_TOP (ColTop)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_entry    (pop_entry),
		.event_valid  (event_valid),
		.event_ready  (event_ready),
		.kind         (kind),
		.field_byte   (field_byte),
		.column_index (column_index)
	);

endmodule
